FILE: hw/rtl/pifc_pkg.sv
// Package for the page framer: codes, constants, command record and CRC helper.
// Used by pifc_front, pifc_cmd_queue, pifc_back and isp_page_framer_crc16.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pifc_pkg;

   // Page geometry
   localparam int unsigned PAGE_BYTES = 4096;
   localparam int unsigned LEN_W      = 13;
   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned CRC_W      = 16;

   localparam logic [LEN_W-1:0]  PAGE_LEN   = LEN_W'(PAGE_BYTES);
   localparam logic [ADDR_W-1:0] PAGE_STEP  = ADDR_W'(PAGE_BYTES);
   localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h1021;
   localparam logic [CRC_W-1:0]  CRC_INIT   = 16'h1021;

   // Opcodes of an input transaction
   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   // Command queue depth
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Output sequencing steps
   localparam int unsigned STEP_W           = 4;
   localparam logic [STEP_W-1:0] STEP_FIRST       = 4'd0;
   localparam logic [STEP_W-1:0] STEP_PRIMER_LAST = 4'd7;
   localparam logic [STEP_W-1:0] STEP_BEGIN_LAST  = 4'd15;
   localparam logic [STEP_W-1:0] STEP_CRC_HIGH    = 4'd3;
   localparam logic [STEP_W-1:0] STEP_CRC_LAST    = 4'd4;

   // Kind of work handed from front to back
   typedef enum logic [1:0] {
      CMD_ERROR     = 2'd0,
      CMD_BEGIN     = 2'd1,
      CMD_DATA      = 2'd2,
      CMD_DATA_LAST = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic [7:0]              data_byte;
      logic [ADDR_W-1:0]       address;
      logic [LEN_W-1:0]        length;
      logic [CRC_W-1:0]        crc;
   } cmd_type;

   // Fixed write primer
   function automatic logic [7:0] primer_byte(input logic [2:0] idx);
      logic [7:0] b;
      begin
         case (idx)
            3'd0:    b = 8'h51;
            3'd1:    b = 8'h85;
            3'd2:    b = 8'hc2;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h00;
            3'd5:    b = 8'h03;
            3'd6:    b = 8'h10;
            3'd7:    b = 8'he3;
            default: b = 8'h00;
         endcase
         return b;
      end
   endfunction

   // One byte of CRC-16, MSB first
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [7:0] d);
      logic [CRC_W-1:0] c;
      logic [7:0]       dd;
      logic             top;
      begin
         c  = crc;
         dd = d;
         for (int i = 0; i < 8; i++) begin
            top = dd[7] ^ c[CRC_W-1];
            c   = {c[CRC_W-2:0], 1'b0};
            if (top) begin
               c = c ^ CRC_POLY;
            end
            dd = {dd[6:0], 1'b0};
         end
         return c;
      end
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pifc_cmd_queue.sv
// Short command queue between the front and back parts of the page framer.
// Depends on pifc_pkg for the command record and depth.
`timescale 1ns / 1ps
`default_nettype none

module pifc_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire pifc_pkg::cmd_type push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output pifc_pkg::cmd_type      head_cmd
);

   pifc_pkg::cmd_type                  slot_ff [pifc_pkg::QUEUE_DEPTH];
   logic [pifc_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [pifc_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [pifc_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                               do_push, do_pop;

   assign full     = (count_ff == pifc_pkg::QCNT_W'(pifc_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/pifc_front.sv
// Front part of the page framer: accepts transactions, checks order, keeps
// page address, running CRC and byte count. Depends on pifc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pifc_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         accept,
   input  wire logic                         opcode,
   input  wire logic                         first_page,
   input  wire logic [pifc_pkg::LEN_W-1:0]   page_length,
   input  wire logic [7:0]                   data_byte,
   output pifc_pkg::cmd_type                 cmd
);

   logic [pifc_pkg::ADDR_W-1:0] page_address_ff, page_address_in;
   logic [pifc_pkg::CRC_W-1:0]  running_crc_ff, running_crc_in;
   logic [pifc_pkg::LEN_W-1:0]  bytes_remaining_ff, bytes_remaining_in;
   logic [pifc_pkg::CRC_W-1:0]  crc_next;
   logic [pifc_pkg::ADDR_W-1:0] begin_address;
   logic                        page_open;
   logic                        length_ok;

   assign page_open     = (bytes_remaining_ff != '0);
   assign length_ok     = (page_length != '0) && (page_length <= pifc_pkg::PAGE_LEN);
   assign crc_next      = pifc_pkg::crc_byte(running_crc_ff, data_byte);
   assign begin_address = first_page ? '0 : page_address_ff;

   // Classify the transaction and work out the next state
   always_comb begin
      page_address_in    = page_address_ff;
      running_crc_in     = running_crc_ff;
      bytes_remaining_in = bytes_remaining_ff;
      cmd.kind           = pifc_pkg::CMD_ERROR;
      cmd.data_byte      = data_byte;
      cmd.address        = begin_address;
      cmd.length         = page_length;
      cmd.crc            = crc_next;
      if (opcode == pifc_pkg::OP_BEGIN) begin
         if (!page_open && length_ok) begin
            cmd.kind           = pifc_pkg::CMD_BEGIN;
            page_address_in    = begin_address;
            running_crc_in     = pifc_pkg::CRC_INIT;
            bytes_remaining_in = page_length;
         end
      end else if (page_open) begin
         running_crc_in     = crc_next;
         bytes_remaining_in = bytes_remaining_ff - 1'b1;
         if (bytes_remaining_ff == pifc_pkg::LEN_W'(1)) begin
            cmd.kind        = pifc_pkg::CMD_DATA_LAST;
            page_address_in = page_address_ff + pifc_pkg::PAGE_STEP;
         end else begin
            cmd.kind = pifc_pkg::CMD_DATA;
         end
      end
   end

   // Hold state between transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         page_address_ff    <= '0;
         running_crc_ff     <= pifc_pkg::CRC_INIT;
         bytes_remaining_ff <= '0;
      end else if (accept) begin
         page_address_ff    <= page_address_in;
         running_crc_ff     <= running_crc_in;
         bytes_remaining_ff <= bytes_remaining_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/pifc_back.sv
// Back part of the page framer: expands queued commands into output bytes
// and holds the result register. Depends on pifc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pifc_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_empty,
   input  wire pifc_pkg::cmd_type cmd,
   output logic                   cmd_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_end_of_write,
   output logic                   rsp_sequence_error
);

   logic [pifc_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        out_valid_ff, out_valid_in;
   logic [7:0]                  out_byte_ff, out_byte_in;
   logic                        eow_ff, eow_in;
   logic                        err_ff, err_in;
   logic                        emit;
   logic                        last_step;
   logic [pifc_pkg::ADDR_W-1:0] word;

   function automatic logic [7:0] be_byte(input logic [pifc_pkg::ADDR_W-1:0] w,
                                          input logic [1:0] idx);
      logic [7:0] b;
      begin
         case (idx)
            2'd0:    b = w[31:24];
            2'd1:    b = w[23:16];
            2'd2:    b = w[15:8];
            2'd3:    b = w[7:0];
            default: b = 8'h00;
         endcase
         return b;
      end
   endfunction

   assign emit = !cmd_empty && (!out_valid_ff || rsp_pop);

   // Pick the byte for the current step of the head command
   always_comb begin
      out_byte_in = 8'h00;
      eow_in      = 1'b0;
      err_in      = 1'b0;
      last_step   = (step_ff == pifc_pkg::STEP_FIRST);
      word        = cmd.address;
      case (cmd.kind)
         pifc_pkg::CMD_ERROR: begin
            err_in = 1'b1;
         end
         pifc_pkg::CMD_DATA: begin
            out_byte_in = cmd.data_byte;
         end
         pifc_pkg::CMD_DATA_LAST: begin
            last_step = (step_ff == pifc_pkg::STEP_CRC_LAST);
            if (step_ff == pifc_pkg::STEP_FIRST) begin
               out_byte_in = cmd.data_byte;
            end else if (step_ff == pifc_pkg::STEP_CRC_HIGH) begin
               out_byte_in = cmd.crc[15:8];
            end else if (step_ff == pifc_pkg::STEP_CRC_LAST) begin
               out_byte_in = cmd.crc[7:0];
               eow_in      = 1'b1;
            end
         end
         pifc_pkg::CMD_BEGIN: begin
            last_step = (step_ff == pifc_pkg::STEP_BEGIN_LAST);
            eow_in    = (step_ff == pifc_pkg::STEP_PRIMER_LAST);
            if (step_ff[3]) begin
               word        = step_ff[2] ? pifc_pkg::ADDR_W'(cmd.length) : cmd.address;
               out_byte_in = be_byte(word, step_ff[1:0]);
            end else begin
               out_byte_in = pifc_pkg::primer_byte(step_ff[2:0]);
            end
         end
         default: begin
            err_in = 1'b1;
         end
      endcase
   end

   assign cmd_pop = emit && last_step;

   // Advance the step counter and the result register
   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         step_in      = last_step ? pifc_pkg::STEP_FIRST : step_ff + 1'b1;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= pifc_pkg::STEP_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff <= out_byte_in;
         eow_ff      <= eow_in;
         err_ff      <= err_in;
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_end_of_write   = eow_ff;
   assign rsp_sequence_error = err_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/isp_page_framer_crc16.sv
// Page framer with CRC-16: top level joining front, command queue and back.
// Depends on pifc_pkg, pifc_front, pifc_cmd_queue and pifc_back.
//
// Usage:
//   Input channel (req_*): push a transaction while req_full is low. Opcode
//   0 opens a page (primer, address, length: 16 result bytes), opcode 1
//   carries one data byte (1 result, or 5 on the last byte of a page, the
//   last four being the CRC, zero-extended). An out-of-order or bad
//   transaction gives one result with rsp_sequence_error set and a zero byte.
//   Result channel (rsp_*): while rsp_empty is low the oldest result is on
//   the rsp_ ports; assert rsp_pop to take it.
//   A transaction passes through the command queue and then the result
//   register before its first result appears. Throughput: one result byte
//   per cycle while rsp_pop is held, set by the back sequencer; data bytes
//   then sustain one transaction per cycle, a page open occupies the back for
//   its 16 result bytes while the front keeps accepting into a four-entry queue.
//   Reset: page address zero, no page open, CRC at its initial value,
//   queue and result register empty.
//   Receiver stall: the result register holds, the queue fills and req_full
//   rises; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module isp_page_framer_crc16 (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic                        req_opcode,
   input  wire logic                        req_first_page,
   input  wire logic [pifc_pkg::LEN_W-1:0]  req_page_length,
   input  wire logic [7:0]                  req_data_byte,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_end_of_write,
   output logic                             rsp_sequence_error
);

   pifc_pkg::cmd_type front_cmd;
   pifc_pkg::cmd_type head_cmd;
   logic              accept;
   logic              queue_empty;
   logic              queue_pop;

   assign accept = req_push && !req_full;

   // Classify and track page state
   pifc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .opcode      (req_opcode),
      .first_page  (req_first_page),
      .page_length (req_page_length),
      .data_byte   (req_data_byte),
      .cmd         (front_cmd)
   );

   // Decouple front and back
   pifc_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (front_cmd),
      .full     (req_full),
      .pop      (queue_pop),
      .empty    (queue_empty),
      .head_cmd (head_cmd)
   );

   // Expand commands into the byte stream
   pifc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_empty          (queue_empty),
      .cmd                (head_cmd),
      .cmd_pop            (queue_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_end_of_write   (rsp_end_of_write),
      .rsp_sequence_error (rsp_sequence_error)
   );

endmodule

`default_nettype wire

FILE: dv/isp_page_framer_crc16_tb.sv
// Self-checking testbench for the CRC-16 page framer: directed and random pages.
// Depends on pifc_pkg and isp_page_framer_crc16; holds its own framing predictor.
`timescale 1ns / 1ps

module isp_page_framer_crc16_tb;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 160;
   localparam int LONG_PAGE_LEN = 40;
   localparam int HOLD_OFF_LEN  = 300;
   localparam int IDLE_PERCENT  = 22;
   localparam int REPORT_LIMIT  = 10;
   localparam int TAIL_CYCLES   = 16;
   localparam logic [pifc_pkg::LEN_W-1:0] LEN_ALL_ONES = '1;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_write;
      logic       sequence_error;
   } frame_byte_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic                       req_opcode = 1'b0;
   logic                       req_first_page = 1'b0;
   logic [pifc_pkg::LEN_W-1:0] req_page_length = '0;
   logic [7:0]                 req_data_byte = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic [7:0]                 rsp_out_byte;
   logic                       rsp_end_of_write;
   logic                       rsp_sequence_error;

   // Predictor state
   logic [pifc_pkg::ADDR_W-1:0] next_page_address = '0;
   logic [pifc_pkg::CRC_W-1:0]  page_crc = pifc_pkg::CRC_INIT;
   logic [pifc_pkg::LEN_W-1:0]  bytes_left = '0;
   frame_byte_type              expected_stream [$];

   // Traffic shaping and bookkeeping
   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;
   int hold_off_request = 0;
   int hold_left = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int transactions_sent = 0;
   int pages_opened = 0;
   int rejects_predicted = 0;
   int bytes_checked = 0;
   int full_stall_cycles = 0;

   isp_page_framer_crc16 dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_opcode         (req_opcode),
      .req_first_page     (req_first_page),
      .req_page_length    (req_page_length),
      .req_data_byte      (req_data_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_end_of_write   (rsp_end_of_write),
      .rsp_sequence_error (rsp_sequence_error)
   );

   always #6 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d result bytes outstanding",
                  cycle_count, expected_stream.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Fixed write primer, one byte per index
   function automatic logic [7:0] write_primer(input int idx);
      logic [7:0] b;
      case (idx)
         0:       b = 8'h51;
         1:       b = 8'h85;
         2:       b = 8'hc2;
         3:       b = 8'h00;
         4:       b = 8'h00;
         5:       b = 8'h03;
         6:       b = 8'h10;
         7:       b = 8'he3;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // CRC-16, polynomial 0x1021, one byte MSB first
   function automatic logic [pifc_pkg::CRC_W-1:0] crc16_update(
         input logic [pifc_pkg::CRC_W-1:0] crc, input logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = crc[pifc_pkg::CRC_W-1] ^ d[i];
         crc = {crc[pifc_pkg::CRC_W-2:0], 1'b0} ^ (fb ? pifc_pkg::CRC_POLY : '0);
      end
      return crc;
   endfunction

   function automatic void push_expected(input logic [7:0] b, input logic eow,
                                         input logic err);
      frame_byte_type fb;
      fb.out_byte       = b;
      fb.end_of_write   = eow;
      fb.sequence_error = err;
      expected_stream.push_back(fb);
   endfunction

   function automatic void push_word(input logic [31:0] w, input logic eow);
      push_expected(w[31:24], 1'b0, 1'b0);
      push_expected(w[23:16], 1'b0, 1'b0);
      push_expected(w[15:8], 1'b0, 1'b0);
      push_expected(w[7:0], eow, 1'b0);
   endfunction

   // Work out the write-stream bytes caused by one accepted transaction
   function automatic void predict_frame_bytes(input logic op, input logic first,
                                               input logic [pifc_pkg::LEN_W-1:0] len,
                                               input logic [7:0] data);
      if (op == pifc_pkg::OP_BEGIN) begin
         if (bytes_left != 0 || len == 0 || len > pifc_pkg::PAGE_BYTES) begin
            rejects_predicted++;
            push_expected(8'h00, 1'b0, 1'b1);
         end else begin
            pages_opened++;
            if (first) begin
               next_page_address = '0;
            end
            for (int i = 0; i < 8; i++) begin
               push_expected(write_primer(i), i == 7, 1'b0);
            end
            push_word(next_page_address, 1'b0);
            push_word(32'(len), 1'b0);
            page_crc   = pifc_pkg::CRC_INIT;
            bytes_left = len;
         end
      end else if (bytes_left == 0) begin
         rejects_predicted++;
         push_expected(8'h00, 1'b0, 1'b1);
      end else begin
         push_expected(data, 1'b0, 1'b0);
         page_crc   = crc16_update(page_crc, data);
         bytes_left = bytes_left - 1'b1;
         if (bytes_left == 0) begin
            push_word({16'h0000, page_crc}, 1'b1);
            next_page_address = next_page_address + pifc_pkg::PAGE_STEP;
         end
      end
   endfunction

   // Offer one transaction, hold it until accepted, then predict its output
   task automatic send_item(input logic op, input logic first,
                            input logic [pifc_pkg::LEN_W-1:0] len,
                            input logic [7:0] data);
      if (send_idle_on) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_push <= 1'b0;
            @(posedge clock);
         end
      end
      req_push        <= 1'b1;
      req_opcode      <= op;
      req_first_page  <= first;
      req_page_length <= len;
      req_data_byte   <= data;
      @(posedge clock);
      while (req_full) begin
         full_stall_cycles++;
         @(posedge clock);
      end
      transactions_sent++;
      predict_frame_bytes(op, first, len, data);
   endtask

   task automatic wait_results_drained();
      req_push <= 1'b0;
      while (expected_stream.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic close_open_page();
      while (bytes_left != 0) begin
         send_item(pifc_pkg::OP_DATA, 1'(($urandom_range(1))),
                   pifc_pkg::LEN_W'($urandom_range(8191)), 8'($urandom_range(255)));
      end
   endtask

   function automatic logic [pifc_pkg::LEN_W-1:0] random_page_length();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 85) begin
         return pifc_pkg::LEN_W'($urandom_range(12, 1));
      end else if (roll < 97) begin
         return pifc_pkg::LEN_W'($urandom_range(64, 13));
      end
      return pifc_pkg::LEN_W'($urandom_range(512, 65));
   endfunction

   task automatic note_mismatch(input string what, input frame_byte_type want,
                                input frame_byte_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s: expected byte %02h eow %0b err %0b, got byte %02h eow %0b err %0b",
                  $realtime, what, want.out_byte, want.end_of_write, want.sequence_error,
                  got.out_byte, got.end_of_write, got.sequence_error);
      end
   endtask

   // Check each popped result and choose the next pop
   always @(posedge clock) begin : check_results
      frame_byte_type got;
      frame_byte_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got.out_byte       = rsp_out_byte;
            got.end_of_write   = rsp_end_of_write;
            got.sequence_error = rsp_sequence_error;
            bytes_checked++;
            if (expected_stream.size() == 0) begin
               note_mismatch("unexpected result", '0, got);
            end else begin
               want = expected_stream.pop_front();
               if (got.out_byte !== want.out_byte ||
                   got.end_of_write !== want.end_of_write ||
                   got.sequence_error !== want.sequence_error) begin
                  note_mismatch("result mismatch", want, got);
               end
            end
         end
         // Pick up a hold-off request and count it down here
         if (hold_off_request != 0) begin
            hold_left        = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (recv_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Out-of-order transactions and bad lengths, with state kept across them
   task automatic test_rejections();
      send_item(pifc_pkg::OP_DATA, 1'b1, LEN_ALL_ONES, 8'hff);
      send_item(pifc_pkg::OP_BEGIN, 1'b1, '0, 8'h00);
      send_item(pifc_pkg::OP_BEGIN, 1'b1, pifc_pkg::LEN_W'(pifc_pkg::PAGE_BYTES + 1), 8'hff);
      send_item(pifc_pkg::OP_BEGIN, 1'b0, LEN_ALL_ONES, 8'h00);
      send_item(pifc_pkg::OP_BEGIN, 1'b0, 13'd2, 8'h00);
      send_item(pifc_pkg::OP_BEGIN, 1'b1, pifc_pkg::PAGE_LEN, 8'hff);
      send_item(pifc_pkg::OP_DATA, 1'b0, '0, 8'h00);
      send_item(pifc_pkg::OP_DATA, 1'b1, LEN_ALL_ONES, 8'hff);
      send_item(pifc_pkg::OP_DATA, 1'b0, '0, 8'h11);
      wait_results_drained();
   endtask

   // Short pages: address reset, address advance, extreme data bytes
   task automatic test_short_pages();
      send_item(pifc_pkg::OP_BEGIN, 1'b1, 13'd1, 8'hff);
      send_item(pifc_pkg::OP_DATA, 1'b0, '0, 8'hff);
      send_item(pifc_pkg::OP_BEGIN, 1'b0, 13'd3, 8'h00);
      send_item(pifc_pkg::OP_DATA, 1'b1, LEN_ALL_ONES, 8'h00);
      send_item(pifc_pkg::OP_DATA, 1'b0, '0, 8'h80);
      send_item(pifc_pkg::OP_DATA, 1'b0, '0, 8'h5a);
      send_item(pifc_pkg::OP_BEGIN, 1'b0, 13'd5, 8'h3c);
      for (int i = 0; i < 5; i++) begin
         send_item(pifc_pkg::OP_DATA, 1'b0, '0, 8'(8'h01 << i));
      end
      send_item(pifc_pkg::OP_BEGIN, 1'b1, 13'd2, 8'h00);
      send_item(pifc_pkg::OP_DATA, 1'b0, '0, 8'h01);
      send_item(pifc_pkg::OP_DATA, 1'b0, '0, 8'hfe);
      wait_results_drained();
   endtask

   // Long page streamed back to back with no idling on either side
   task automatic test_long_page();
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      send_item(pifc_pkg::OP_BEGIN, 1'b0, pifc_pkg::LEN_W'(LONG_PAGE_LEN),
                8'(($urandom_range(255))));
      close_open_page();
      wait_results_drained();
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
   endtask

   // Hold the receiver off while pages keep coming, so the input stalls
   task automatic test_receiver_hold_off();
      hold_off_request = HOLD_OFF_LEN;
      send_item(pifc_pkg::OP_BEGIN, 1'b1, 13'd24, 8'h00);
      close_open_page();
      send_item(pifc_pkg::OP_BEGIN, 1'b0, 13'd3, 8'h00);
      send_item(pifc_pkg::OP_BEGIN, 1'b0, 13'd3, 8'h00);
      close_open_page();
      wait_results_drained();
   endtask

   // Mostly well-formed pages with random content, plus noise
   task automatic test_random_traffic();
      int unsigned roll;
      int sent;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         roll = $urandom_range(99);
         if (bytes_left != 0) begin
            if (roll < 94) begin
               send_item(pifc_pkg::OP_DATA, 1'($urandom_range(1)),
                         pifc_pkg::LEN_W'($urandom_range(8191)), 8'($urandom_range(255)));
            end else begin
               send_item(pifc_pkg::OP_BEGIN, 1'($urandom_range(1)), random_page_length(),
                         8'($urandom_range(255)));
            end
         end else if (roll < 84) begin
            send_item(pifc_pkg::OP_BEGIN, 1'($urandom_range(3) == 0), random_page_length(),
                      8'($urandom_range(255)));
         end else if (roll < 92) begin
            send_item(pifc_pkg::OP_DATA, 1'($urandom_range(1)),
                      pifc_pkg::LEN_W'($urandom_range(8191)), 8'($urandom_range(255)));
         end else if (roll < 95) begin
            send_item(pifc_pkg::OP_BEGIN, 1'($urandom_range(1)), '0,
                      8'($urandom_range(255)));
         end else begin
            send_item(pifc_pkg::OP_BEGIN, 1'($urandom_range(1)),
                      pifc_pkg::LEN_W'($urandom_range(8191, pifc_pkg::PAGE_BYTES + 1)),
                      8'($urandom_range(255)));
         end
         sent++;
      end
      close_open_page();
      wait_results_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_rejections();
      test_short_pages();
      test_long_page();
      test_receiver_hold_off();
      test_random_traffic();
      // Let any stray output surface before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_stream.size() != 0) begin
         $display("%0d expected result bytes never arrived", expected_stream.size());
         mismatch_count += expected_stream.size();
      end
      $display("Sent %0d transactions: %0d pages opened, %0d rejected; %0d result bytes checked",
               transactions_sent, pages_opened, rejects_predicted, bytes_checked);
      $display("Input stalled on full for %0d cycles; %0d mismatches",
               full_stall_cycles, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: isp_page_framer_crc16.f
hw/rtl/pifc_pkg.sv
hw/rtl/pifc_cmd_queue.sv
hw/rtl/pifc_front.sv
hw/rtl/pifc_back.sv
hw/rtl/isp_page_framer_crc16.sv
dv/isp_page_framer_crc16_tb.sv
